FILE: design/assert_macros.svh
// assertion helpers used by the positional list engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a implies b in the same cycle, off during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: implication");

// property a implies b in the next cycle, off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next cycle");

// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, a) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
        else $error("assertion failed: forbidden condition");

`endif

FILE: design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Types and codes shared by the positional list engine and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_BAD_POS = 2'd3;

    localparam int POS_W = 5;
    localparam int LEN_W = 5;
    localparam int DAT_W = 32;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_ROTATE
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [DAT_W-1:0] value;
        logic [POS_W-1:0]        position;
    } req_t;

    typedef struct packed {
        logic signed [DAT_W-1:0] data;
        logic [LEN_W-1:0]        length;
        logic [1:0]              status;
        logic                    last;
    } res_t;

endpackage

`default_nettype wire

FILE: design/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list with insert and remove at 1-based positions, and dump.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. It
//   carries command, value and position (0 means the tail).
//   Results come out on result for one cycle each, flagged by strobe; the
//   receiver cannot stall them, so it must take every strobed cycle.
//   Insert, remove and the unused code give one result the cycle after the
//   request; busy stays low and a new request may follow every cycle.
//   Dump of n entries gives n results on consecutive cycles, head first, last
//   set on the final one; the request moves the sequencer to the dump state,
//   which registers each result. busy is high in the dump state while the
//   cell chain rotates one slot per cycle into cell 0, which feeds the output,
//   so the next request is taken on the edge that takes the final dump result.
//   Dump of an empty list gives one result the cycle after the request.
//   Each insert or remove that is not refused is one shift of the cell chain.
//   Reset clears the length to zero and idles the sequencer; stored entries
//   are not cleared and are never read until written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module positional_list_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire ple_pkg::req_t request,
    output logic               strobe,
    output ple_pkg::res_t      result
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ple_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              strobe_reg, strobe_next;
    ple_pkg::res_t     res_reg, res_next;

    ple_pkg::cell_op_t cell_op;
    logic [CW-1:0]     slot;
    logic [DATA_WIDTH-1:0] val_w;
    logic [DATA_WIDTH-1:0] cell_q [DEPTH];
    logic [ple_pkg::DAT_W-1:0] head_data;

    logic              accept;
    logic [CMPW-1:0]   pos_x;
    logic [CMPW-1:0]   cnt_x;
    logic              dump_last;

    assign accept    = start && (state_reg == ple_pkg::S_IDLE);
    assign pos_x     = CMPW'(request.position);
    assign cnt_x     = CMPW'(count_reg);
    assign dump_last = (idx_reg == (count_reg - CW'(1)));

    // value into storage width
    generate
        if (DATA_WIDTH <= ple_pkg::DAT_W)
        begin : g_val_cut
            assign val_w = request.value[DATA_WIDTH-1:0];
        end
        else
        begin : g_val_ext
            assign val_w = {{(DATA_WIDTH-ple_pkg::DAT_W){request.value[ple_pkg::DAT_W-1]}},
                            request.value};
        end
    endgenerate

    // head entry out to the data field, cut or sign extended
    generate
        if (DATA_WIDTH >= ple_pkg::DAT_W)
        begin : g_head_cut
            assign head_data = cell_q[0][ple_pkg::DAT_W-1:0];
        end
        else
        begin : g_head_ext
            assign head_data = {{(ple_pkg::DAT_W-DATA_WIDTH){cell_q[0][DATA_WIDTH-1]}},
                                cell_q[0]};
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (accept && request.command == ple_pkg::CMD_DUMP && count_reg != '0)
                    state_next = ple_pkg::S_DUMP;
            end
            ple_pkg::S_DUMP:
            begin
                if (dump_last)
                    state_next = ple_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    // outputs, cell control and result
    always_comb
    begin
        busy          = 1'b0;
        cell_op       = ple_pkg::OP_HOLD;
        slot          = '0;
        count_next    = count_reg;
        idx_next      = idx_reg;
        strobe_next   = 1'b0;
        res_next      = res_reg;
        case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    strobe_next     = 1'b1;
                    res_next.data   = '0;
                    res_next.status = ple_pkg::ST_OK;
                    res_next.last   = 1'b1;
                    idx_next        = '0;
                    case (request.command)
                        ple_pkg::CMD_INSERT:
                        begin
                            if (count_reg == FULL_CNT)
                                res_next.status = ple_pkg::ST_FULL;
                            else if (pos_x > cnt_x + CMPW'(1))
                                res_next.status = ple_pkg::ST_BAD_POS;
                            else
                            begin
                                cell_op    = ple_pkg::OP_INSERT;
                                slot       = (request.position == '0) ? count_reg
                                                                     : CW'(pos_x - CMPW'(1));
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ple_pkg::CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                                res_next.status = ple_pkg::ST_EMPTY;
                            else if (pos_x > cnt_x)
                                res_next.status = ple_pkg::ST_BAD_POS;
                            else
                            begin
                                cell_op    = ple_pkg::OP_REMOVE;
                                slot       = (request.position == '0) ? (count_reg - CW'(1))
                                                                     : CW'(pos_x - CMPW'(1));
                                count_next = count_reg - CW'(1);
                            end
                        end
                        ple_pkg::CMD_DUMP:
                        begin
                            // non-empty dump is streamed from the dump state
                            if (count_reg == '0)
                                res_next.status = ple_pkg::ST_EMPTY;
                            else
                                strobe_next = 1'b0;
                        end
                        default:
                        begin
                            res_next.status = ple_pkg::ST_OK;
                        end
                    endcase
                    res_next.length = ple_pkg::LEN_W'(count_next);
                end
            end
            ple_pkg::S_DUMP:
            begin
                busy            = 1'b1;
                cell_op         = ple_pkg::OP_ROTATE;
                strobe_next     = 1'b1;
                res_next.data   = head_data;
                res_next.length = ple_pkg::LEN_W'(count_reg);
                res_next.status = ple_pkg::ST_OK;
                res_next.last   = dump_last;
                idx_next        = idx_reg + CW'(1);
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_d;
            logic [DATA_WIDTH-1:0] right_d;
            if (i == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_q[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign right_d = cell_q[i];
            end
            else
            begin : g_mid_r
                assign right_d = cell_q[i+1];
            end

            ple_cell #(
                .DW  (DATA_WIDTH),
                .CW  (CW),
                .IDX (i)
            ) u_cell (
                .clk   (clk),
                .op    (cell_op),
                .slot  (slot),
                .count (count_reg),
                .value (val_w),
                .left  (left_d),
                .right (right_d),
                .head  (cell_q[0]),
                .q     (cell_q[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ple_pkg::S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

    `ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > FULL_CNT)
    `ASSERT_IMPLY(a_dump_nonempty, clk, rst_n, busy, count_reg != '0)
    `ASSERT_IMPLY(a_more_follows, clk, rst_n, strobe && !result.last, busy)
    `ASSERT_NEXT(a_dump_streams, clk, rst_n, busy, strobe)

endmodule

`default_nettype wire

FILE: design/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry and takes the new value, its left or right
// neighbor or the head on insert, remove and dump rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell #(
    parameter int DW  = 32,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  wire logic             clk,
    input  wire ple_pkg::cell_op_t op,
    input  wire logic [CW-1:0]    slot,
    input  wire logic [CW-1:0]    count,
    input  wire logic [DW-1:0]    value,
    input  wire logic [DW-1:0]    left,
    input  wire logic [DW-1:0]    right,
    input  wire logic [DW-1:0]    head,
    output logic      [DW-1:0]    q
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [DW-1:0] entry_reg;
    logic [DW-1:0] entry_next;
    logic [CW-1:0] tail_idx;

    assign tail_idx = count - CW'(1);

    always_comb
    begin
        entry_next = entry_reg;
        case (op)
            ple_pkg::OP_INSERT:
            begin
                if (slot == MY_IDX)
                    entry_next = value;
                else if (slot < MY_IDX)
                    entry_next = left;
            end
            ple_pkg::OP_REMOVE:
            begin
                if (slot <= MY_IDX)
                    entry_next = right;
            end
            ple_pkg::OP_ROTATE:
            begin
                // tail wraps back to the old head
                if (tail_idx == MY_IDX)
                    entry_next = head;
                else
                    entry_next = right;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

`default_nettype wire
